// ----- rtl/mbfr_pkg.sv -----
`timescale 1ns / 1ps

package mbfr_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int ACC_W        = 72;

  localparam logic [2:0] ACT_LOAD        = 3'd0;
  localparam logic [2:0] ACT_READ_BITS   = 3'd1;
  localparam logic [2:0] ACT_READ_SIGNED = 3'd2;
  localparam logic [2:0] ACT_REALIGN     = 3'd3;
  localparam logic [2:0] ACT_MOVE        = 3'd4;
  localparam logic [2:0] ACT_READ_BYTE   = 3'd5;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_MOVE  = 2'd1;
  localparam logic [1:0] ERR_COUNT = 2'd2;
  localparam logic [1:0] ERR_END   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_SHIFT,
    ST_EXTEND,
    ST_RESP
  } state_t;

endpackage

// ----- rtl/msb_first_bit_field_reader.sv -----
`timescale 1ns / 1ps

// Command-style MSB-first bit reader over a byte buffer. An item is taken when start is high
// and busy is low; its result is shown for exactly one cycle with done high, and the receiver
// cannot stall it, so it must take every result as it comes. A read that needs n buffer bytes
// (up to nine for a 64-bit read) goes through the check, fetch, shift and extend states; the
// bytes come from the byte memory's read port one per cycle. A read that fails its check or
// follows a failure, and any other action, goes from check straight to the result state.
// No item is taken until busy falls after the result. The byte memory has no reset; reading
// bytes never loaded gives unspecified data. Write buffer_length only while the block is idle.
module msb_first_bit_field_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [11:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [6:0]  bit_count,
  input  logic [12:0] target_position,
  output logic        done,
  output logic [63:0] field_value,
  output logic [1:0]  error_code,
  output logic        has_failed
);

  import mbfr_pkg::*;

  state_t state;
  state_t state_next;

  logic [12:0]       length;
  logic [POS_W-1:0]  valid_len;
  logic [POS_W-1:0]  pos;
  logic [2:0]        bp;
  logic              failed;

  logic [2:0]        act;
  logic [11:0]       addr;
  logic [7:0]        data;
  logic [6:0]        cnt;
  logic [12:0]       target;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  shifted;
  logic [ADDR_W-1:0] fetch_addr;
  logic [3:0]        left;
  logic              rd_pend;
  logic              first;
  logic [7:0]        lead_mask;
  logic [3:0]        discard;
  logic [63:0]       value;
  logic [1:0]        err;

  logic [7:0]        end_bit;
  logic [3:0]        need_u;
  logic [3:0]        need_chk;
  logic [7:0]        discard_full;
  logic [POS_W:0]    rem;
  logic              short;
  logic              count_bad;
  logic              target_bad;
  logic              addr_ok;
  logic [1:0]        chk_err;
  logic              chk_fetch;
  logic [5:0]        sidx;

  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  mbfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(addr)),
    .wdata (data),
    .re    (ram_re),
    .raddr (fetch_addr),
    .rdata (ram_rdata)
  );

  assign valid_len = (32'(length) > 32'(BUFFER_DEPTH)) ? POS_W'(BUFFER_DEPTH) : POS_W'(length);

  always_comb begin
    end_bit      = 8'(bp) + 8'(cnt);
    need_u       = (end_bit == 8'd0) ? 4'd1 : 4'(((end_bit - 8'd1) >> 3) + 8'd1);
    discard_full = {1'b0, need_u, 3'b000} - end_bit;
    case (act)
      ACT_READ_SIGNED: need_chk = (cnt == 7'd1 && bp == 3'd7) ? 4'd2 : need_u;
      ACT_READ_BYTE:   need_chk = 4'd1;
      default:         need_chk = need_u;
    endcase
    rem        = {1'b0, valid_len} - {1'b0, pos};
    short      = rem[POS_W] || (rem[POS_W-1:0] < POS_W'(need_chk));
    count_bad  = cnt > 7'd64;
    target_bad = 32'(target) > 32'(valid_len);
    addr_ok    = 32'(addr) < 32'(BUFFER_DEPTH);
    sidx       = 6'(cnt - 7'd1);
    shifted    = acc >> discard;
  end

  always_comb begin
    chk_err   = ERR_OK;
    chk_fetch = 1'b0;
    case (act)
      ACT_READ_BITS: begin
        if (count_bad) chk_err = ERR_COUNT;
        else if (short) chk_err = ERR_END;
        else chk_fetch = 1'b1;
      end
      ACT_READ_SIGNED: begin
        if (count_bad) chk_err = ERR_COUNT;
        else if (short) chk_err = ERR_END;
        else if (cnt == 7'd0) chk_err = ERR_COUNT;
        else chk_fetch = 1'b1;
      end
      ACT_READ_BYTE: begin
        if (short) chk_err = ERR_END;
        else chk_fetch = 1'b1;
      end
      ACT_MOVE: begin
        if (target_bad) chk_err = ERR_MOVE;
      end
      default: ;
    endcase
    if (failed) begin
      chk_err   = ERR_OK;
      chk_fetch = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_CHECK;
      ST_CHECK:  state_next = chk_fetch ? ST_FETCH : ST_RESP;
      ST_FETCH:  if (left == 4'd0 && rd_pend) state_next = ST_SHIFT;
      ST_SHIFT:  state_next = ST_EXTEND;
      ST_EXTEND: state_next = ST_RESP;
      ST_RESP:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = state != ST_IDLE;
    done   = state == ST_RESP;
    ram_we = state == ST_CHECK && act == ACT_LOAD && addr_ok;
    ram_re = state == ST_FETCH && left != 4'd0;
  end

  assign field_value = value;
  assign error_code  = err;
  assign has_failed  = failed;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cfg_we) begin
      length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pos     <= '0;
      bp      <= '0;
      failed  <= 1'b0;
      rd_pend <= 1'b0;
      left    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            act    <= action;
            addr   <= byte_address;
            data   <= byte_value;
            cnt    <= bit_count;
            target <= target_position;
          end
        end
        ST_CHECK: begin
          value      <= '0;
          err        <= chk_err;
          acc        <= '0;
          fetch_addr <= ADDR_W'(pos);
          left       <= (act == ACT_READ_BYTE) ? 4'd1 : need_u;
          rd_pend    <= 1'b0;
          first      <= 1'b1;
          lead_mask  <= (act == ACT_READ_BYTE) ? 8'hFF : (8'hFF >> bp);
          discard    <= (act == ACT_READ_BYTE) ? 4'd0 : discard_full[3:0];
          if (chk_err != ERR_OK) begin
            failed <= 1'b1;
          end
          if (!failed) begin
            if (act == ACT_REALIGN && bp != 3'd0) begin
              bp  <= '0;
              pos <= pos + POS_W'(1);
            end
            if (act == ACT_MOVE && !target_bad) begin
              bp  <= '0;
              pos <= POS_W'(target);
            end
          end
        end
        ST_FETCH: begin
          rd_pend <= left != 4'd0;
          if (left != 4'd0) begin
            fetch_addr <= fetch_addr + ADDR_W'(1);
            left       <= left - 4'd1;
          end
          if (rd_pend) begin
            acc   <= {acc[ACC_W-9:0], first ? (ram_rdata & lead_mask) : ram_rdata};
            first <= 1'b0;
          end
        end
        ST_SHIFT: begin
          value <= shifted[63:0];
          if (act == ACT_READ_BYTE) begin
            pos <= pos + POS_W'(1);
          end else begin
            pos <= pos + POS_W'(end_bit >> 3);
            bp  <= end_bit[2:0];
          end
        end
        ST_EXTEND: begin
          if (act == ACT_READ_SIGNED && value[sidx]) begin
            value <= value | (~64'd0 << sidx);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    done && error_code != ERR_OK |-> has_failed && field_value == 64'd0)
    else $error("failing item without sticky flag or with nonzero value");

  assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("sticky failure cleared outside reset");

  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not start work");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- rtl/mbfr_ram.sv -----
`timescale 1ns / 1ps

module mbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/bit_reader_check.sv -----
`timescale 1ns / 1ps

module bit_reader_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  action,
  input  logic [11:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [6:0]  bit_count,
  input  logic [12:0] target_position,
  input  logic        done,
  input  logic [63:0] field_value,
  input  logic [1:0]  error_code,
  input  logic        has_failed,
  output int          outstanding,
  output int          mismatches
);

  import mbfr_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  err;
    logic        failed;
  } reading_t;

  logic [7:0]  shadow_mem [BUFFER_DEPTH];
  int unsigned cur_byte;
  int unsigned cur_bit;
  int unsigned valid_bytes;
  logic        stuck;
  reading_t    pending_reads [$];

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 50) begin
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic [1:0] take_msb_bits(input int unsigned n, output logic [63:0] bits);
    int unsigned need;
    int unsigned pos;
    bits = '0;
    if (n > 64) begin
      return ERR_COUNT;
    end
    need = (cur_bit + n == 0) ? 1 : (cur_bit + n - 1) / 8 + 1;
    if (cur_byte > valid_bytes || valid_bytes - cur_byte < need) begin
      return ERR_END;
    end
    for (int i = 0; i < n; i++) begin
      pos = cur_bit + i;
      bits = {bits[62:0], shadow_mem[ADDR_W'(cur_byte + pos / 8)][3'(7 - pos % 8)]};
    end
    cur_byte += (cur_bit + n) / 8;
    cur_bit = (cur_bit + n) % 8;
    return ERR_OK;
  endfunction

  function automatic reading_t decode_action(input logic [2:0] act, input logic [11:0] addr,
                                             input logic [7:0] data, input logic [6:0] count,
                                             input logic [12:0] dest);
    reading_t    r;
    logic [63:0] sign_bit;
    logic [63:0] rest;
    r = '0;
    sign_bit = '0;
    rest = '0;
    if (act == ACT_LOAD) begin
      shadow_mem[addr] = data;
    end else if (!stuck && act <= ACT_READ_BYTE) begin
      case (act)
        ACT_READ_BITS: begin
          r.err = take_msb_bits(32'(count), rest);
          r.value = rest;
        end
        ACT_READ_SIGNED: begin
          if (count > 64) begin
            r.err = ERR_COUNT;
          end else begin
            r.err = take_msb_bits(1, sign_bit);
            if (r.err == ERR_OK && count == 0) begin
              r.err = ERR_COUNT;
            end else if (r.err == ERR_OK) begin
              r.err = take_msb_bits(32'(count) - 1, rest);
            end
            if (r.err == ERR_OK) begin
              r.value = sign_bit[0] ? ((~64'd0 << (32'(count) - 1)) | rest) : rest;
            end
          end
        end
        ACT_REALIGN: begin
          if (cur_bit != 0) begin
            cur_bit = 0;
            cur_byte++;
          end
        end
        ACT_MOVE: begin
          if (32'(dest) > valid_bytes) begin
            r.err = ERR_MOVE;
          end else begin
            cur_byte = 32'(dest);
            cur_bit = 0;
          end
        end
        default: begin
          if (cur_byte >= valid_bytes) begin
            r.err = ERR_END;
          end else begin
            r.value = 64'(shadow_mem[ADDR_W'(cur_byte)]);
            cur_byte++;
          end
        end
      endcase
      if (r.err != ERR_OK) begin
        stuck = 1'b1;
        r.value = '0;
      end
    end
    r.failed = stuck;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      cur_byte = 0;
      cur_bit = 0;
      valid_bytes = 0;
      stuck = 1'b0;
      pending_reads.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (pending_reads.size() == 0) begin
          note_mismatch("result with no item waiting", field_value, 64'd0);
        end else begin
          want = pending_reads.pop_front();
          if (field_value !== want.value) begin
            note_mismatch("field_value", field_value, want.value);
          end
          if (error_code !== want.err) begin
            note_mismatch("error_code", 64'(error_code), 64'(want.err));
          end
          if (has_failed !== want.failed) begin
            note_mismatch("has_failed", 64'(has_failed), 64'(want.failed));
          end
        end
      end
      if (cfg_we) begin
        valid_bytes = (32'(cfg_wdata) > 32'(BUFFER_DEPTH)) ? 32'(BUFFER_DEPTH) : 32'(cfg_wdata);
      end
      if (start && !busy) begin
        pending_reads.push_back(decode_action(action, byte_address, byte_value, bit_count,
                                              target_position));
      end
      outstanding <= pending_reads.size();
    end
  end

endmodule

// ----- verif/tb_msb_first_bit_field_reader.sv -----
`timescale 1ns / 1ps

module tb_msb_first_bit_field_reader;
  import mbfr_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int         READ_SPAN   = 320;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [11:0] byte_address;
  logic [7:0]  byte_value;
  logic [6:0]  bit_count;
  logic [12:0] target_position;
  logic        done;
  logic [63:0] field_value;
  logic [1:0]  error_code;
  logic        has_failed;
  int          outstanding;
  int          mismatches;

  // next item fields and stimulus-side view of the read position
  logic [11:0] f_addr;
  logic [7:0]  f_val;
  logic [6:0]  f_cnt;
  logic [12:0] f_tgt;
  int          read_byte;
  int          read_bit;
  int          limit_bytes;
  bit          written [BUFFER_DEPTH];
  bit          no_gaps;
  int          items_sent;
  int          lengths_used;

  msb_first_bit_field_reader DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .byte_address    (byte_address),
    .byte_value      (byte_value),
    .bit_count       (bit_count),
    .target_position (target_position),
    .done            (done),
    .field_value     (field_value),
    .error_code      (error_code),
    .has_failed      (has_failed)
  );

  bit_reader_check reader_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .byte_address    (byte_address),
    .byte_value      (byte_value),
    .bit_count       (bit_count),
    .target_position (target_position),
    .done            (done),
    .field_value     (field_value),
    .error_code      (error_code),
    .has_failed      (has_failed),
    .outstanding     (outstanding),
    .mismatches      (mismatches)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int free_bits();
    if (read_byte < limit_bytes) begin
      return (limit_bytes - read_byte) * 8 - read_bit;
    end
    return 0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_count(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom_range(lo, (hi < lo + 8) ? hi : lo + 8);
    end
    if (r < 6) begin
      return hi;
    end
    return $urandom_range(lo, hi);
  endfunction

  task automatic shuffle_fields();
    f_addr = 12'($urandom_range(0, 4095));
    f_val = 8'($urandom_range(0, 255));
    f_cnt = 7'($urandom_range(0, 127));
    f_tgt = 13'($urandom_range(0, 8191));
  endtask

  task automatic send_item(input logic [2:0] act);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    byte_address <= f_addr;
    byte_value <= f_val;
    bit_count <= f_cnt;
    target_position <= f_tgt;
    do @(posedge clk); while (busy);
    items_sent++;
    case (act)
      ACT_LOAD: written[f_addr] = 1'b1;
      ACT_READ_BITS, ACT_READ_SIGNED: begin
        read_byte += (read_bit + int'(f_cnt)) / 8;
        read_bit = (read_bit + int'(f_cnt)) % 8;
      end
      ACT_REALIGN: begin
        if (read_bit != 0) begin
          read_bit = 0;
          read_byte++;
        end
      end
      ACT_MOVE: begin
        read_byte = int'(f_tgt);
        read_bit = 0;
      end
      ACT_READ_BYTE: read_byte++;
      default: ;
    endcase
  endtask

  task automatic directed(input logic [2:0] act, input int cnt, input int tgt);
    shuffle_fields();
    f_cnt = 7'(cnt);
    f_tgt = 13'(tgt);
    send_item(act);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // stimulus reads stay in the first bytes, all loaded before the length is set
  task automatic set_length(input int v);
    int fill;
    bit saved;
    fill = (v > BUFFER_DEPTH) ? BUFFER_DEPTH : v;
    fill = (fill > READ_SPAN) ? READ_SPAN : fill;
    saved = no_gaps;
    no_gaps = 1'b1;
    for (int a = 0; a < fill; a++) begin
      if (!written[a]) begin
        shuffle_fields();
        f_addr = 12'(a);
        send_item(ACT_LOAD);
      end
    end
    no_gaps = saved;
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 13'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_bytes = fill;
    lengths_used++;
  endtask

  // mostly legal actions, with spare action codes now and then; a read that cannot fit turns into a move
  task automatic random_item();
    int pick;
    int room;
    int top_n;
    shuffle_fields();
    pick = $urandom_range(0, 99);
    room = free_bits();
    top_n = (room < 64) ? room : 64;
    if (pick < 14) begin
      if (limit_bytes > 0 && $urandom_range(0, 1) == 1) begin
        f_addr = 12'($urandom_range(0, limit_bytes - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
        f_val = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
      send_item(ACT_LOAD);
    end else if (pick < 44 && room >= 1) begin
      f_cnt = 7'(pick_count(0, top_n));
      send_item(ACT_READ_BITS);
    end else if (pick >= 44 && pick < 66 && room >= 2) begin
      f_cnt = 7'(pick_count(1, top_n));
      send_item(ACT_READ_SIGNED);
    end else if (pick >= 66 && pick < 76) begin
      send_item(ACT_REALIGN);
    end else if (pick >= 90 && pick < 97 && read_byte < limit_bytes) begin
      send_item(ACT_READ_BYTE);
    end else if (pick >= 97) begin
      send_item(($urandom_range(0, 1) == 1) ? ACT_SPARE_6 : ACT_SPARE_7);
    end else begin
      case ($urandom_range(0, 3))
        0: f_tgt = 13'(limit_bytes);
        1: f_tgt = (limit_bytes > 2) ? 13'(limit_bytes - int'($urandom_range(0, 2))) : 13'd0;
        default: f_tgt = 13'($urandom_range(0, limit_bytes));
      endcase
      send_item(ACT_MOVE);
    end
  endtask

  initial begin
    logic [7:0] seed_bytes [10];
    int         phase_len [10];
    string      cause_name [8];
    int         cause;
    int         tgt_pos;
    seed_bytes = '{8'hFF, 8'h80, 8'h00, 8'h5A, 8'hFF, 8'hFF, 8'hA5, 8'h7F, 8'h01, 8'hC3};
    phase_len = '{1, 2, 9, 0, 64, 17, 5, 200, 33, 3};
    cause_name = '{"oversized unsigned count", "oversized signed count", "zero signed count",
                   "move past length", "unsigned read at end", "byte read at end",
                   "sign bit on last bit", "length lowered under position"};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    action = ACT_LOAD;
    byte_address = '0;
    byte_value = '0;
    bit_count = '0;
    target_position = '0;
    read_byte = 0;
    read_bit = 0;
    limit_bytes = 0;
    no_gaps = 1'b0;
    items_sent = 0;
    lengths_used = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty buffer: nothing may read
    directed(ACT_SPARE_6, 0, 0);
    directed(ACT_REALIGN, 0, 0);
    directed(ACT_MOVE, 0, 0);
    for (int a = 0; a < 10; a++) begin
      shuffle_fields();
      f_addr = 12'(a);
      f_val = seed_bytes[a];
      send_item(ACT_LOAD);
    end
    shuffle_fields();
    f_addr = 12'hFFF;
    f_val = 8'h00;
    send_item(ACT_LOAD);
    set_length(10);
    directed(ACT_READ_BITS, 0, 0);
    directed(ACT_READ_BITS, 64, 0);
    directed(ACT_MOVE, 0, 0);
    directed(ACT_READ_SIGNED, 64, 0);
    directed(ACT_MOVE, 0, 1);
    directed(ACT_READ_SIGNED, 1, 0);
    directed(ACT_REALIGN, 0, 0);
    directed(ACT_READ_BYTE, 0, 0);
    directed(ACT_READ_BITS, 3, 0);
    directed(ACT_READ_BYTE, 0, 0);
    directed(ACT_MOVE, 0, 9);
    directed(ACT_READ_BITS, 8, 0);
    directed(ACT_MOVE, 0, 10);

    phase_len[5] = $urandom_range(3, 24);
    phase_len[8] = $urandom_range(25, 300);
    foreach (phase_len[p]) begin
      set_length(phase_len[p]);
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (55) random_item();
    end
    set_length(8191);
    no_gaps = ($urandom_range(0, 4) == 0);
    repeat (30) random_item();

    // the failure flag is sticky until reset, so only one cause per run
    cause = $urandom_range(0, 7);
    case (cause)
      0: directed(ACT_READ_BITS, $urandom_range(65, 127), 0);
      1: directed(ACT_READ_SIGNED, $urandom_range(65, 127), 0);
      2: begin
        directed(ACT_MOVE, 0, 0);
        directed(ACT_READ_SIGNED, 0, 0);
      end
      3: directed(ACT_MOVE, 0, $urandom_range(4097, 8191));
      4: begin
        directed(ACT_MOVE, 0, 4096);
        directed(ACT_READ_BITS, $urandom_range(0, 64), 0);
      end
      5: begin
        directed(ACT_MOVE, 0, 4096);
        directed(ACT_READ_BYTE, 0, 0);
      end
      6: begin
        directed(ACT_MOVE, 0, 4095);
        directed(ACT_READ_BITS, 7, 0);
        directed(ACT_READ_SIGNED, 1, 0);
      end
      default: begin
        tgt_pos = $urandom_range(1, 4096);
        directed(ACT_MOVE, 0, tgt_pos);
        set_length($urandom_range(0, tgt_pos - 1));
        directed(ACT_READ_BITS, $urandom_range(0, 64), 0);
      end
    endcase
    repeat (24) begin
      shuffle_fields();
      send_item(3'($urandom_range(0, 7)));
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("%0d items over %0d buffer length settings, including one above the buffer depth",
             items_sent, lengths_used);
    $display("sticky failure provoked by %s, then every action checked after it",
             cause_name[cause]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("simulation failed");
    $finish;
  end

endmodule
